// File: sv/sfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and codes for the symbol frequency sort block.
// ----------------------------------------------------------------------------
package sfs_pkg;

  // operation codes
  localparam logic [1:0] OP_COUNT = 2'd0;
  localparam logic [1:0] OP_FETCH = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] symbol;
    logic [7:0] rank;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  sorted_symbol;
    logic [15:0] symbol_count;
    logic        entry_valid;
    logic [8:0]  distinct_total;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_SORT_INIT,
    ST_SCAN,
    ST_SORT_LAST,
    ST_SORT_WR,
    ST_FET_ORD,
    ST_FET_CNT,
    ST_FET_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic clear;
    logic cnt_rd;
    logic cnt_wr;
    logic sort_init;
    logic scan_issue;
    logic sort_wr;
    logic set_sorted;
    logic fet_cnt;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       sym_ok;
    logic       sorted;
    logic       distinct_zero;
    logic       scan_done;
    logic       pos_last;
    logic       out_busy;
    logic [8:0] distinct_total;
  } status_t;

endpackage
`default_nettype wire

// File: sv/sfs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfs_ctrl
// Sequencer for count, clear, sort passes and fetch.
// ----------------------------------------------------------------------------
module sfs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sfs_pkg::status_t sts,
  output sfs_pkg::cmd_t         cmd
);

  sfs_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      sfs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (sts.op)
            sfs_pkg::OP_COUNT: begin
              if (sts.sym_ok) state_next = sfs_pkg::ST_CNT_RD;
            end
            sfs_pkg::OP_FETCH: begin
              state_next = sts.sorted ? sfs_pkg::ST_FET_ORD : sfs_pkg::ST_SORT_INIT;
            end
            sfs_pkg::OP_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      sfs_pkg::ST_CNT_RD: begin
        cmd.cnt_rd = 1'b1;
        state_next = sfs_pkg::ST_CNT_WR;
      end
      sfs_pkg::ST_CNT_WR: begin
        cmd.cnt_wr = 1'b1;
        state_next = sfs_pkg::ST_IDLE;
      end
      sfs_pkg::ST_SORT_INIT: begin
        cmd.sort_init = 1'b1;
        if (sts.distinct_zero) begin
          cmd.set_sorted = 1'b1;
          state_next     = sfs_pkg::ST_FET_ORD;
        end else begin
          state_next = sfs_pkg::ST_SCAN;
        end
      end
      sfs_pkg::ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_done) state_next = sfs_pkg::ST_SORT_LAST;
      end
      sfs_pkg::ST_SORT_LAST: begin
        state_next = sfs_pkg::ST_SORT_WR;
      end
      sfs_pkg::ST_SORT_WR: begin
        cmd.sort_wr = 1'b1;
        if (sts.pos_last) begin
          cmd.set_sorted = 1'b1;
          state_next     = sfs_pkg::ST_FET_ORD;
        end else begin
          state_next = sfs_pkg::ST_SCAN;
        end
      end
      sfs_pkg::ST_FET_ORD: begin
        state_next = sfs_pkg::ST_FET_CNT;
      end
      sfs_pkg::ST_FET_CNT: begin
        cmd.fet_cnt = 1'b1;
        state_next  = sfs_pkg::ST_FET_OUT;
      end
      sfs_pkg::ST_FET_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = sfs_pkg::ST_IDLE;
        end
      end
      default: state_next = sfs_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/sfs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfs_dp
// Count store, order store, selection scan and output register.
// ----------------------------------------------------------------------------
module sfs_dp #(
  parameter int COUNT_WIDTH = 16,
  parameter int SYMBOLS     = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sfs_pkg::in_item_t  in_data,
  input  wire sfs_pkg::cmd_t      cmd,
  output sfs_pkg::status_t        sts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sfs_pkg::out_item_t      out_data
);

  localparam int AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] count_mem [SYMBOLS];
  logic [SYMBOLS-1:0]     vbits;
  logic [7:0]             order_mem [256];

  sfs_pkg::in_item_t      in_q;
  logic [COUNT_WIDTH-1:0] cnt_rd;
  logic                   vld_rd;
  logic [7:0]             ord_rd;
  logic [8:0]             distinct;
  logic                   sorted;
  logic [7:0]             key;
  logic [7:0]             key_q;
  logic                   inr_q;
  logic                   scan_live;
  logic [COUNT_WIDTH-1:0] best_cnt;
  logic [7:0]             best_key;
  logic                   best_valid;
  logic [COUNT_WIDTH-1:0] prev_cnt;
  logic [7:0]             prev_key;
  logic                   first;
  logic [8:0]             pos;

  logic [7:0]             scan_sym;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic [COUNT_WIDTH-1:0] eff_cnt;
  logic                   cand_ok;
  logic [31:0]            cnt32;
  logic [15:0]            cnt_sat;
  logic                   rank_ok;

  assign scan_sym = key ^ 8'h80;
  assign rd_en    = cmd.cnt_rd | cmd.scan_issue | cmd.fet_cnt;
  assign wr_addr  = in_q.symbol[AW-1:0];
  assign eff_cnt  = vld_rd ? cnt_rd : '0;

  // count store read address
  always_comb begin
    if (cmd.scan_issue) begin
      rd_addr = scan_sym[AW-1:0];
    end else if (cmd.fet_cnt) begin
      rd_addr = ord_rd[AW-1:0];
    end else begin
      rd_addr = in_q.symbol[AW-1:0];
    end
  end

  // count store read and write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cnt_rd <= count_mem[rd_addr];
      vld_rd <= vbits[rd_addr];
    end
    if (cmd.cnt_wr) begin
      count_mem[wr_addr] <= (eff_cnt == COUNT_MAX) ? eff_cnt : eff_cnt + 1'b1;
    end
  end

  // written flags, distinct count and sorted flag
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      vbits    <= '0;
      distinct <= '0;
      sorted   <= 1'b0;
    end else begin
      if (cmd.cnt_wr) begin
        vbits[wr_addr] <= 1'b1;
        if (!vld_rd) distinct <= distinct + 9'd1;
        sorted <= 1'b0;
      end else if (cmd.set_sorted) begin
        sorted <= 1'b1;
      end
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) in_q <= in_data;
  end

  // candidate must follow the last placed entry and beat the current best
  assign cand_ok = scan_live && inr_q && vld_rd &&
                   (first || ({cnt_rd, key_q} > {prev_cnt, prev_key})) &&
                   (!best_valid || (cnt_rd < best_cnt));

  // selection scan, one key per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_live  <= 1'b0;
      best_valid <= 1'b0;
      first      <= 1'b1;
      key        <= '0;
      pos        <= '0;
    end else begin
      scan_live <= cmd.scan_issue;
      key_q     <= key;
      inr_q     <= ({1'b0, scan_sym} < 9'(SYMBOLS));
      if (cmd.scan_issue) key <= key + 8'd1;
      if (cand_ok) begin
        best_cnt   <= cnt_rd;
        best_key   <= key_q;
        best_valid <= 1'b1;
      end
      if (cmd.sort_init) begin
        pos        <= '0;
        first      <= 1'b1;
        best_valid <= 1'b0;
        key        <= '0;
      end else if (cmd.sort_wr) begin
        prev_cnt   <= best_cnt;
        prev_key   <= best_key;
        first      <= 1'b0;
        pos        <= pos + 9'd1;
        best_valid <= 1'b0;
        key        <= '0;
      end
    end
  end

  // order store
  always_ff @(posedge clk) begin
    if (cmd.sort_wr) order_mem[pos[7:0]] <= best_key ^ 8'h80;
    ord_rd <= order_mem[in_q.rank];
  end

  // result fields
  assign cnt32   = 32'(cnt_rd);
  assign cnt_sat = (cnt32 > 32'h0000_FFFF) ? 16'hFFFF : cnt32[15:0];
  assign rank_ok = ({1'b0, in_q.rank} < distinct);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.sorted_symbol  <= rank_ok ? ord_rd : 8'd0;
      out_data.symbol_count   <= (rank_ok && vld_rd) ? cnt_sat : 16'd0;
      out_data.entry_valid    <= rank_ok;
      out_data.distinct_total <= distinct;
    end
  end

  // status
  assign sts.op             = in_data.opcode;
  assign sts.sym_ok         = ({1'b0, in_data.symbol} < 9'(SYMBOLS));
  assign sts.sorted         = sorted;
  assign sts.distinct_zero  = (distinct == 9'd0);
  assign sts.scan_done      = (key == 8'hFF);
  assign sts.pos_last       = ((pos + 9'd1) == distinct);
  assign sts.out_busy       = out_valid && !out_ready;
  assign sts.distinct_total = distinct;

endmodule
`default_nettype wire

// File: sv/symbol_frequency_sort.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// symbol_frequency_sort
// Byte histogram with an ascending frequency sort and ranked fetch.
// ----------------------------------------------------------------------------
// A count item is accepted, reads the count store and writes back; a clear
// is applied on acceptance; a fetch reads the order table, then the count
// store, then loads the output register when free. The first fetch after a
// count or clear first rebuilds the order table by selection: one pass over
// all 256 keys per distinct symbol through the single read port of the count
// store. Ties order by signed byte value. Items are taken one at a time;
// count and clear items are accepted while a fetch result waits at the output.
// ----------------------------------------------------------------------------
module symbol_frequency_sort #(
  parameter int COUNT_WIDTH = 16,
  parameter int SYMBOLS     = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sfs_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sfs_pkg::out_item_t      out_data
);

  sfs_pkg::cmd_t    cmd;
  sfs_pkg::status_t sts;

  // sequencer
  sfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and scan
  sfs_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .SYMBOLS     (SYMBOLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // clear empties the distinct count
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.opcode == sfs_pkg::OP_CLEAR)
      |=> (sts.distinct_total == 9'd0))
    else $error("distinct count not cleared");

  // a valid entry implies at least one distinct symbol
  a_valid_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.entry_valid) |-> (out_data.distinct_total != 9'd0))
    else $error("valid entry with empty table");

  // an out of range rank returns zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.entry_valid)
      |-> (out_data.sorted_symbol == 8'd0 && out_data.symbol_count == 16'd0))
    else $error("invalid entry carries data");

  // distinct count never exceeds the alphabet
  a_distinct_max: assert property (@(posedge clk) disable iff (rst)
    sts.distinct_total <= 9'(SYMBOLS))
    else $error("distinct count over alphabet size");
`endif

endmodule
`default_nettype wire
